>>> hw/rtl/pfdb_pkg.sv
// Shared types, constants and helpers for the port frame deframer and batcher.
package pfdb_pkg;

   localparam int NUM_PORTS    = 8;
   localparam int RECORD_BYTES = 64;
   localparam int POS_W        = $clog2(RECORD_BYTES);
   localparam int PORT_W       = 3;
   localparam int CNT_W        = 4;

   localparam logic [7:0] HDR_BYTE0     = 8'h05;
   localparam logic [7:0] HDR_BYTE1     = 8'h64;
   localparam logic [7:0] HDR_NIB_MASK  = 8'hF0;
   localparam logic [7:0] HDR_NIB_VALUE = 8'hA0;
   localparam logic [7:0] PORT_CODE_LO  = 8'hE1;
   localparam logic [7:0] PORT_CODE_HI  = 8'hE8;

   // Header bytes skipped between the marker and the length byte.
   localparam logic [2:0] HDR_SKIP = 3'd4;

   localparam logic [CNT_W-1:0] RPB_RESET = 4'd15;

   // Register index (byte address / 4).
   localparam logic REG_RECORDS_PER_BATCH = 1'b0;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'b001,
      PH_HEADER  = 3'b010,
      PH_PAYLOAD = 3'b100
   } phase_type;

   function automatic logic [PORT_W-1:0] port_of(input logic [7:0] b);
      logic [7:0] idx;
      idx = b - PORT_CODE_LO;
      if (b >= PORT_CODE_LO && b <= PORT_CODE_HI && idx < 8'(NUM_PORTS))
         return idx[PORT_W-1:0];
      return '0;
   endfunction

endpackage

>>> hw/rtl/port_frame_deframer_batcher.sv
// Top level of the port frame deframer and record batcher.
//
// Usage:
//  - req_* channel: one received stream byte per transfer (req_in_byte).
//  - rsp_* channel: one record byte per transfer, with its port, pad flag,
//    record_end on the last byte of each record and batch_end on the last
//    byte of a record that closes a batch for its port.
//  - APB port (psel/penable/pwrite/paddr/pwdata/prdata/pready): register 0 at
//    address 0 is records_per_batch (4 bits, reset 15, 0 acts like 1).
//    pready is tied high; write it only while the block is idle.
// Timing:
//  - A byte sits in the input register and is then loaded into the result
//    register, from which a payload byte shows on rsp_*. Throughput is one
//    byte per cycle while rsp_* is not stalled and no padding runs.
//  - After the last payload byte the pad counter emits RECORD_BYTES - length
//    zero bytes, one per cycle unless stalled (a zero length byte emits the
//    first itself); the input register holds one more byte; req_ready is low.
//  - When rsp_valid is high and rsp_ready is low the result register holds,
//    the input register still takes one byte, then req_ready drops.
//  - Synchronous reset empties both registers, restarts the header hunt,
//    clears all per-port record counts and sets records_per_batch to 15.
module port_frame_deframer_batcher (
   input  logic                         clock,
   input  logic                         reset,
   // input stream
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_in_byte,
   // record bytes
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [pfdb_pkg::PORT_W-1:0]  rsp_port,
   output logic [7:0]                   rsp_data_byte,
   output logic                         rsp_is_pad,
   output logic                         rsp_record_end,
   output logic                         rsp_batch_end,
   // configuration
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [2:0]                   paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

   localparam logic [pfdb_pkg::POS_W-1:0] LAST_POS =
      pfdb_pkg::POS_W'(pfdb_pkg::RECORD_BYTES - 1);

   // ---------------- configuration ----------------
   logic [pfdb_pkg::CNT_W-1:0] rpb_ff, rpb_in;
   logic                       csr_wr;
   logic                       csr_idx;

   assign pready  = 1'b1;
   assign csr_idx = paddr[2];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_comb begin
      rpb_in = rpb_ff;
      if (csr_wr && csr_idx == pfdb_pkg::REG_RECORDS_PER_BATCH) begin
         rpb_in = pwdata[pfdb_pkg::CNT_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (csr_idx == pfdb_pkg::REG_RECORDS_PER_BATCH) begin
         prdata = 32'(rpb_ff);
      end
   end

   // ---------------- state ----------------
   logic                        in_valid_ff, in_valid_in;
   logic [7:0]                  in_byte_ff;
   pfdb_pkg::phase_type         phase_ff, phase_in;
   logic [15:0]                 prev_ff, prev_in;
   logic [1:0]                  fill_ff, fill_in;
   logic [2:0]                  hdr_cnt_ff, hdr_cnt_in;
   logic [7:0]                  frame_len_ff, frame_len_in;
   logic [7:0]                  pay_cnt_ff, pay_cnt_in;
   logic [pfdb_pkg::PORT_W-1:0] cur_port_ff, cur_port_in;
   logic                        pad_active_ff, pad_active_in;
   logic [pfdb_pkg::POS_W-1:0]  pad_pos_ff, pad_pos_in;
   logic [pfdb_pkg::CNT_W-1:0]  rec_cnt_ff [2**pfdb_pkg::PORT_W];

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [pfdb_pkg::PORT_W-1:0] rsp_port_ff;
   logic [7:0]                  rsp_data_ff;
   logic                        rsp_pad_ff, rsp_rend_ff, rsp_bend_ff;

   // ---------------- datapath ----------------
   logic                        advance;   // result register can load
   logic                        take;      // input byte consumed this cycle
   logic                        emit;
   logic [7:0]                  emit_data;
   logic                        emit_pad;
   logic [pfdb_pkg::POS_W-1:0]  emit_pos;
   logic [pfdb_pkg::PORT_W-1:0] emit_port;
   logic                        emit_rend;
   logic                        emit_bend;
   logic [pfdb_pkg::CNT_W:0]    cnt_next;
   logic [8:0]                  pay_next;
   logic [pfdb_pkg::PORT_W-1:0] port_sel;
   logic                        hdr_match;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign take      = advance && in_valid_ff && !pad_active_ff;
   assign req_ready = !in_valid_ff || take;

   assign hdr_match = prev_ff[15:8] == pfdb_pkg::HDR_BYTE0
                   && prev_ff[7:0] == pfdb_pkg::HDR_BYTE1
                   && (in_byte_ff & pfdb_pkg::HDR_NIB_MASK) == pfdb_pkg::HDR_NIB_VALUE;
   assign pay_next  = {1'b0, pay_cnt_ff} + 9'd1;
   assign port_sel  = (pay_cnt_ff == 8'd0) ? pfdb_pkg::port_of(in_byte_ff) : cur_port_ff;

   always_comb begin
      phase_in      = phase_ff;
      prev_in       = prev_ff;
      fill_in       = fill_ff;
      hdr_cnt_in    = hdr_cnt_ff;
      frame_len_in  = frame_len_ff;
      pay_cnt_in    = pay_cnt_ff;
      cur_port_in   = cur_port_ff;
      pad_active_in = pad_active_ff;
      pad_pos_in    = pad_pos_ff;
      emit          = 1'b0;
      emit_data     = '0;
      emit_pad      = 1'b0;
      emit_pos      = '0;
      emit_port     = cur_port_ff;

      if (advance && pad_active_ff) begin
         // padding burst: one zero byte per cycle while the result register can load
         emit       = 1'b1;
         emit_pad   = 1'b1;
         emit_pos   = pad_pos_ff;
         pad_pos_in = pad_pos_ff + pfdb_pkg::POS_W'(1);
         if (pad_pos_ff == LAST_POS) begin
            pad_active_in = 1'b0;
         end
      end else if (take) begin
         case (phase_ff)
            pfdb_pkg::PH_HUNT: begin
               if (fill_ff < 2'd2) begin
                  prev_in = {prev_ff[7:0], in_byte_ff};
                  fill_in = fill_ff + 2'd1;
               end else if (hdr_match) begin
                  phase_in   = pfdb_pkg::PH_HEADER;
                  hdr_cnt_in = '0;
                  fill_in    = '0;
                  prev_in    = '0;
               end else begin
                  prev_in = {prev_ff[7:0], in_byte_ff};
               end
            end
            pfdb_pkg::PH_HEADER: begin
               if (hdr_cnt_ff < pfdb_pkg::HDR_SKIP) begin
                  hdr_cnt_in = hdr_cnt_ff + 3'd1;
               end else begin
                  frame_len_in = in_byte_ff;
                  pay_cnt_in   = '0;
                  if (in_byte_ff == 8'd0) begin
                     // empty frame: whole record of padding on port 0
                     cur_port_in   = '0;
                     emit          = 1'b1;
                     emit_pad      = 1'b1;
                     emit_pos      = '0;
                     emit_port     = '0;
                     pad_active_in = 1'b1;
                     pad_pos_in    = pfdb_pkg::POS_W'(1);
                     phase_in      = pfdb_pkg::PH_HUNT;
                     fill_in       = '0;
                     prev_in       = '0;
                     hdr_cnt_in    = '0;
                  end else begin
                     phase_in = pfdb_pkg::PH_PAYLOAD;
                  end
               end
            end
            pfdb_pkg::PH_PAYLOAD: begin
               cur_port_in = port_sel;
               emit_port   = port_sel;
               if ({1'b0, pay_cnt_ff} < 9'(pfdb_pkg::RECORD_BYTES)) begin
                  emit      = 1'b1;
                  emit_data = in_byte_ff;
                  emit_pos  = pay_cnt_ff[pfdb_pkg::POS_W-1:0];
               end
               pay_cnt_in = pay_next[7:0];
               if (pay_next >= {1'b0, frame_len_ff}) begin
                  // end of frame: a short frame pads the rest of the record
                  if ({1'b0, frame_len_ff} < 9'(pfdb_pkg::RECORD_BYTES)) begin
                     pad_active_in = 1'b1;
                     pad_pos_in    = frame_len_ff[pfdb_pkg::POS_W-1:0];
                  end
                  phase_in   = pfdb_pkg::PH_HUNT;
                  fill_in    = '0;
                  prev_in    = '0;
                  hdr_cnt_in = '0;
                  pay_cnt_in = '0;
               end
            end
            default: begin
               phase_in   = pfdb_pkg::PH_HUNT;
               fill_in    = '0;
               prev_in    = '0;
               hdr_cnt_in = '0;
               pay_cnt_in = '0;
            end
         endcase
      end
   end

   // per-port record count, updated on the last byte of each record
   assign emit_rend = emit && emit_pos == LAST_POS;
   assign cnt_next  = {1'b0, rec_cnt_ff[emit_port]} + 5'd1;
   assign emit_bend = emit_rend && cnt_next >= {1'b0, rpb_ff};

   assign rsp_valid_in = advance ? emit : rsp_valid_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rpb_ff        <= pfdb_pkg::RPB_RESET;
         in_valid_ff   <= 1'b0;
         phase_ff      <= pfdb_pkg::PH_HUNT;
         prev_ff       <= '0;
         fill_ff       <= '0;
         hdr_cnt_ff    <= '0;
         frame_len_ff  <= '0;
         pay_cnt_ff    <= '0;
         cur_port_ff   <= '0;
         pad_active_ff <= 1'b0;
         pad_pos_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < 2**pfdb_pkg::PORT_W; i++) begin
            rec_cnt_ff[i] <= '0;
         end
      end else begin
         rpb_ff        <= rpb_in;
         in_valid_ff   <= in_valid_in;
         phase_ff      <= phase_in;
         prev_ff       <= prev_in;
         fill_ff       <= fill_in;
         hdr_cnt_ff    <= hdr_cnt_in;
         frame_len_ff  <= frame_len_in;
         pay_cnt_ff    <= pay_cnt_in;
         cur_port_ff   <= cur_port_in;
         pad_active_ff <= pad_active_in;
         pad_pos_ff    <= pad_pos_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (emit_rend) begin
            rec_cnt_ff[emit_port] <= emit_bend ? '0 : cnt_next[pfdb_pkg::CNT_W-1:0];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
      if (advance && emit) begin
         rsp_port_ff <= emit_port;
         rsp_data_ff <= emit_data;
         rsp_pad_ff  <= emit_pad;
         rsp_rend_ff <= emit_rend;
         rsp_bend_ff <= emit_bend;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_port       = rsp_port_ff;
   assign rsp_data_byte  = rsp_data_ff;
   assign rsp_is_pad     = rsp_pad_ff;
   assign rsp_record_end = rsp_rend_ff;
   assign rsp_batch_end  = rsp_bend_ff;

   // ---------------- assertions ----------------
   a_batch_on_record_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_batch_end |-> rsp_record_end)
      else $error("batch_end without record_end");

   a_pad_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_pad |-> rsp_data_byte == 8'd0)
      else $error("padding byte not zero");

   a_pad_while_hunting: assert property (@(posedge clock) disable iff (reset)
      pad_active_ff |-> phase_ff == pfdb_pkg::PH_HUNT && fill_ff == 2'd0)
      else $error("padding burst overlaps frame parsing");

   a_pad_burst_runs: assert property (@(posedge clock) disable iff (reset)
      pad_active_ff && advance && pad_pos_ff != LAST_POS |=> pad_active_ff)
      else $error("padding burst ended early");

endmodule

>>> bench/port_frame_deframer_batcher_tb.sv
// Self-checking testbench for the port frame deframer and record batcher.
module port_frame_deframer_batcher_tb;

   // Generous bound on the run length.
   localparam int CYCLE_LIMIT   = 500000;
   // Settle time so that any trailing transfer can show.
   localparam int SETTLE_CYCLES = 8;
   localparam int SEG_COUNT     = 4;
   localparam int SEG_ITEMS     = 25;

   localparam logic [2:0] BATCH_SIZE_ADDR = {pfdb_pkg::REG_RECORDS_PER_BATCH, 2'b00};

   // Per random segment: sender idle %, receiver idle %, batch size written.
   // Directed rows and the first two segments run sender 35 / receiver 67,
   // then the roles swap, then both sides stream flat out.
   localparam int         SEG_SEND_IDLE [SEG_COUNT] = '{35, 35, 67, 0};
   localparam int         SEG_RECV_IDLE [SEG_COUNT] = '{67, 67, 35, 0};
   // 15 first (top value), then lowered under the running counts, then
   // 0 (acts like one), then 1: every record closes a batch.
   localparam logic [3:0] SEG_BATCH     [SEG_COUNT] = '{4'd15, 4'd3, 4'd0, 4'd1};

   typedef struct packed {
      logic [pfdb_pkg::PORT_W-1:0] port;
      logic [7:0]                  data_byte;
      logic                        is_pad;
      logic                        record_end;
      logic                        batch_end;
   } record_byte_type;

   // One stream byte; typed rows also state how many record bytes it
   // releases and on which port.
   typedef struct {
      logic [7:0]                  in_byte;
      bit                          typed;
      int unsigned                 n_out;
      logic [pfdb_pkg::PORT_W-1:0] port;
   } dir_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [7:0] req_in_byte;
   logic rsp_valid;
   logic rsp_ready;
   logic [pfdb_pkg::PORT_W-1:0] rsp_port;
   logic [7:0] rsp_data_byte;
   logic rsp_is_pad;
   logic rsp_record_end;
   logic rsp_batch_end;
   logic psel;
   logic penable;
   logic pwrite;
   logic [2:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   port_frame_deframer_batcher uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_port       (rsp_port),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_is_pad     (rsp_is_pad),
      .rsp_record_end (rsp_record_end),
      .rsp_batch_end  (rsp_batch_end),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   // Record bytes predicted but not yet seen on the rsp side, oldest first.
   record_byte_type pending_record_bytes[$];

   int error_count;
   int cycle_count;
   int items_sent;
   int send_idle_pct;
   int recv_idle_pct;
   int pushed_total;

   // Shadow of the deframer state.
   pfdb_pkg::phase_type         sh_phase;
   logic [15:0]                 sh_window;
   logic [1:0]                  sh_window_fill;
   logic [2:0]                  sh_header_count;
   logic [7:0]                  sh_frame_length;
   logic [7:0]                  sh_payload_count;
   logic [pfdb_pkg::PORT_W-1:0] sh_port;
   logic [pfdb_pkg::CNT_W-1:0]  sh_record_count [pfdb_pkg::NUM_PORTS];
   logic [pfdb_pkg::CNT_W-1:0]  sh_batch_size;

   // Directed stream: a slide over a doubled 0x05, a zero-length frame,
   // a one-byte frame on the top port code, and a two-byte frame whose port
   // code lies just below the valid range.
   dir_row_type directed_rows [28] = '{
      '{8'h05, 1'b0, 0, 3'd0},
      '{8'h05, 1'b0, 0, 3'd0},
      '{8'h64, 1'b0, 0, 3'd0},
      '{8'hAF, 1'b0, 0, 3'd0},
      '{8'h00, 1'b0, 0, 3'd0},
      '{8'hFF, 1'b0, 0, 3'd0},
      '{8'h5A, 1'b0, 0, 3'd0},
      '{8'hA5, 1'b0, 0, 3'd0},
      '{8'h00, 1'b1, 64, 3'd0},   // zero length: full pad record, port 0
      '{8'h05, 1'b0, 0, 3'd0},
      '{8'h64, 1'b0, 0, 3'd0},
      '{8'hA0, 1'b0, 0, 3'd0},
      '{8'hFF, 1'b0, 0, 3'd0},
      '{8'hFF, 1'b0, 0, 3'd0},
      '{8'hFF, 1'b0, 0, 3'd0},
      '{8'hFF, 1'b0, 0, 3'd0},
      '{8'h01, 1'b1, 0, 3'd0},
      '{8'hE8, 1'b1, 64, 3'd7},   // last payload byte plus 63 pad bytes
      '{8'h05, 1'b0, 0, 3'd0},
      '{8'h64, 1'b0, 0, 3'd0},
      '{8'hA3, 1'b0, 0, 3'd0},
      '{8'h12, 1'b0, 0, 3'd0},
      '{8'h34, 1'b0, 0, 3'd0},
      '{8'h56, 1'b0, 0, 3'd0},
      '{8'h78, 1'b0, 0, 3'd0},
      '{8'h02, 1'b1, 0, 3'd0},
      '{8'hE0, 1'b1, 1, 3'd0},    // unknown port code falls back to port 0
      '{8'hFF, 1'b1, 63, 3'd0}
   };

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic logic [pfdb_pkg::PORT_W-1:0] code_to_port(logic [7:0] code);
      int idx;
      idx = int'(code) - int'(pfdb_pkg::PORT_CODE_LO);
      if (idx >= 0 && code <= pfdb_pkg::PORT_CODE_HI && idx < pfdb_pkg::NUM_PORTS)
         return pfdb_pkg::PORT_W'(idx);
      return '0;
   endfunction

   function automatic void push_record_byte(logic [7:0] data, logic pad, int unsigned pos);
      record_byte_type r;
      int unsigned nxt;
      r.port       = sh_port;
      r.data_byte  = data;
      r.is_pad     = pad;
      r.record_end = (pos == pfdb_pkg::RECORD_BYTES - 1);
      r.batch_end  = 1'b0;
      if (r.record_end) begin
         // batch size 0 compares like 1: any count closes the batch
         nxt = sh_record_count[sh_port] + 1;
         if (nxt >= sh_batch_size) begin
            r.batch_end = 1'b1;
            sh_record_count[sh_port] = '0;
         end else begin
            sh_record_count[sh_port] = pfdb_pkg::CNT_W'(nxt);
         end
      end
      pending_record_bytes.push_back(r);
      pushed_total++;
   endfunction

   function automatic void pad_record_from(int unsigned first);
      for (int unsigned pos = first; pos < pfdb_pkg::RECORD_BYTES; pos++)
         push_record_byte(8'h00, 1'b1, pos);
   endfunction

   function automatic void restart_hunt();
      sh_phase         = pfdb_pkg::PH_HUNT;
      sh_window        = '0;
      sh_window_fill   = '0;
      sh_header_count  = '0;
      sh_payload_count = '0;
   endfunction

   function automatic void reset_shadow();
      restart_hunt();
      sh_frame_length = '0;
      sh_port         = '0;
      sh_batch_size   = pfdb_pkg::RPB_RESET;
      for (int i = 0; i < pfdb_pkg::NUM_PORTS; i++)
         sh_record_count[i] = '0;
   endfunction

   // Advance the shadow by one accepted stream byte.
   function automatic void deframe_byte(logic [7:0] b);
      int unsigned pos;
      case (sh_phase)
         pfdb_pkg::PH_HUNT: begin
            if (sh_window_fill < 2) begin
               sh_window = {sh_window[7:0], b};
               sh_window_fill++;
            end else if (sh_window[15:8] == pfdb_pkg::HDR_BYTE0 &&
                         sh_window[7:0] == pfdb_pkg::HDR_BYTE1 &&
                         (b & pfdb_pkg::HDR_NIB_MASK) == pfdb_pkg::HDR_NIB_VALUE) begin
               sh_phase        = pfdb_pkg::PH_HEADER;
               sh_header_count = '0;
               sh_window_fill  = '0;
               sh_window       = '0;
            end else begin
               sh_window = {sh_window[7:0], b};
            end
         end
         pfdb_pkg::PH_HEADER: begin
            if (sh_header_count < pfdb_pkg::HDR_SKIP) begin
               sh_header_count++;
            end else begin
               sh_frame_length  = b;
               sh_payload_count = '0;
               if (b == 8'h00) begin
                  sh_port = '0;
                  pad_record_from(0);
                  restart_hunt();
               end else begin
                  sh_phase = pfdb_pkg::PH_PAYLOAD;
               end
            end
         end
         pfdb_pkg::PH_PAYLOAD: begin
            pos = sh_payload_count;
            if (pos == 0)
               sh_port = code_to_port(b);
            // bytes past the record size are swallowed
            if (pos < pfdb_pkg::RECORD_BYTES)
               push_record_byte(b, 1'b0, pos);
            sh_payload_count = 8'(pos + 1);
            if (sh_payload_count >= sh_frame_length) begin
               if (sh_frame_length < pfdb_pkg::RECORD_BYTES)
                  pad_record_from(sh_frame_length);
               restart_hunt();
            end
         end
         default: restart_hunt();
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers; all enter and leave on a falling edge.
   // ---------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
      deframe_byte(b);
      items_sent++;
      @(negedge clock);
   endtask

   // Hold the sender until every predicted record byte is out, plus settle.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_record_bytes.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // APB write of the batch size, then read it back.
   task automatic write_batch_size(input logic [3:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= BATCH_SIZE_ADDR;
      pwdata  <= 32'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      sh_batch_size = value;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[3:0] !== value) begin
         $display("[%0t] batch size readback: expected %0d, got %0h",
                  $time, value, prdata[3:0]);
         error_count++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // One random frame: mostly well formed, sometimes with a broken marker
   // or leading noise. Lengths are mostly short; a few run past 64 bytes.
   task automatic send_frame();
      int unsigned n_noise;
      int unsigned kind;
      int unsigned len;
      int unsigned r;
      logic [7:0] b;
      n_noise = $urandom_range(0, 2);
      kind    = $urandom_range(99);
      repeat (n_noise) send_byte(8'($urandom));
      send_byte(pfdb_pkg::HDR_BYTE0);
      send_byte(pfdb_pkg::HDR_BYTE1);
      if (kind < 15) begin
         // third marker byte with the wrong high nibble
         b = 8'($urandom);
         if ((b & pfdb_pkg::HDR_NIB_MASK) == pfdb_pkg::HDR_NIB_VALUE)
            b = b ^ 8'h10;
         send_byte(b);
      end else begin
         send_byte(pfdb_pkg::HDR_NIB_VALUE | (8'($urandom) & ~pfdb_pkg::HDR_NIB_MASK));
         repeat (pfdb_pkg::HDR_SKIP) send_byte(8'($urandom));
         r = $urandom_range(99);
         if (r < 10)
            len = 0;
         else if (r < 80)
            len = $urandom_range(1, 10);
         else if (r < 98)
            len = $urandom_range(60, 70);
         else
            len = $urandom_range(71, 255);
         send_byte(8'(len));
         for (int unsigned i = 0; i < len; i++) begin
            if (i == 0 && $urandom_range(9) < 7)
               b = pfdb_pkg::PORT_CODE_LO + 8'($urandom_range(0, pfdb_pkg::NUM_PORTS - 1));
            else
               b = 8'($urandom);
            send_byte(b);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Receiver: random back-pressure at the segment's idle rate.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // ---------------------------------------------------------------------
   // Checker: every rsp transfer against the oldest prediction.
   // ---------------------------------------------------------------------
   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("[%0t] %s mismatch: expected %0h, got %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      record_byte_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_record_bytes.size() == 0) begin
            $display("[%0t] unexpected record byte: expected none, got port %0d data %0h",
                     $time, rsp_port, rsp_data_byte);
            error_count++;
         end else begin
            want = pending_record_bytes.pop_front();
            check_field("port", 8'(want.port), 8'(rsp_port));
            check_field("data_byte", want.data_byte, rsp_data_byte);
            check_field("is_pad", 8'(want.is_pad), 8'(rsp_is_pad));
            check_field("record_end", 8'(want.record_end), 8'(rsp_record_end));
            check_field("batch_end", 8'(want.batch_end), 8'(rsp_batch_end));
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL port_frame_deframer_batcher");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      int prior_pushed;
      int added;
      int seg_start;
      bit paused;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_in_byte   = 8'h00;
      rsp_ready     = 1'b0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      error_count   = 0;
      cycle_count   = 0;
      items_sent    = 0;
      pushed_total  = 0;
      send_idle_pct = SEG_SEND_IDLE[0];
      recv_idle_pct = SEG_RECV_IDLE[0];
      reset_shadow();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part runs on the reset batch size.
      foreach (directed_rows[i]) begin
         prior_pushed = pushed_total;
         send_byte(directed_rows[i].in_byte);
         added = pushed_total - prior_pushed;
         if (directed_rows[i].typed) begin
            if (added != directed_rows[i].n_out) begin
               $display("[%0t] row %0d record bytes: expected %0d, got %0d",
                        $time, i, directed_rows[i].n_out, added);
               error_count++;
            end
            // all record bytes of one stream byte share the shadow port
            if (added != 0 && sh_port !== directed_rows[i].port) begin
               $display("[%0t] row %0d port: expected %0d, got %0d", $time, i,
                        directed_rows[i].port, sh_port);
               error_count++;
            end
         end
      end

      // Random segments; the batch size only changes with the block drained.
      for (int s = 0; s < SEG_COUNT; s++) begin
         wait_for_drain();
         send_idle_pct = SEG_SEND_IDLE[s];
         recv_idle_pct = SEG_RECV_IDLE[s];
         write_batch_size(SEG_BATCH[s]);
         seg_start = items_sent;
         paused    = 1'b0;
         while (items_sent - seg_start < SEG_ITEMS) begin
            // once, mid-stream: starve the input until all output is out
            if (s == 1 && !paused && items_sent - seg_start >= SEG_ITEMS / 2) begin
               wait_for_drain();
               paused = 1'b1;
            end
            send_frame();
         end
      end

      wait_for_drain();
      if (error_count == 0)
         $display("PASS port_frame_deframer_batcher");
      else
         $display("FAIL port_frame_deframer_batcher");
      $finish;
   end

endmodule
